>>> hdl/k_stacks_shared_store_assert.svh
// assertion macros shared by the shared-store stack rtl
`ifndef K_STACKS_SHARED_STORE_ASSERT_SVH
`define K_STACKS_SHARED_STORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define KSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/kss_pkg.sv
// types and codes for the shared-store stack block
package kss_pkg;

    localparam int ID_W    = 3;
    localparam int ID_SPAN = 1 << ID_W;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [31:0] UNDERFLOW_VALUE = -32'sd1;

    typedef struct packed {
        logic [1:0]         op;
        logic [ID_W-1:0]    stack_id;
        logic signed [31:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
        logic               stack_empty;
    } result_t;

endpackage

>>> hdl/k_stacks_shared_store.sv
// Up to eight LIFO stacks sharing SLOT_COUNT slots through a free chain. Issue a transaction
// by raising start with cmd while busy is low; the result appears on result, marked by a
// one-cycle done pulse, in the cycle right after the busy cycle: there is no back-pressure.
// busy is high in the cycle after acceptance, while the slot memories are read ahead of
// the read-modify-write of the links, so no new transaction is taken while one is in its busy
// cycle. No clearing pass is needed after reset.
module k_stacks_shared_store #(
    parameter int SLOT_COUNT  = 256,
    parameter int STACK_COUNT = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kss_pkg::cmd_t    cmd,
    output logic             done,
    output kss_pkg::result_t result
);
    import kss_pkg::*;
    `include "k_stacks_shared_store_assert.svh"

    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int PW   = $clog2(SLOT_COUNT + 1);
    localparam int TOPS = (STACK_COUNT < ID_SPAN) ? STACK_COUNT : ID_SPAN;
    localparam int TIW  = (TOPS > 1) ? $clog2(TOPS) : 1;
    localparam logic [PW-1:0] NULL_PTR = PW'(SLOT_COUNT);

    logic [PW-1:0] tops_reg [TOPS];
    logic [PW-1:0] free_head_reg;
    logic          valid_reg;
    logic          done_reg;
    result_t       result_reg;

    logic [1:0]         op_reg;
    logic [TIW-1:0]     idx_reg;
    logic               exists_reg;
    logic signed [31:0] val_reg;
    logic [PW-1:0]      top_reg;

    logic               accept;
    logic               acc_exists;
    logic [TIW-1:0]     acc_idx;
    logic [PW-1:0]      acc_top;
    logic [SW-1:0]      link_raddr;
    logic signed [31:0] val_rdata;
    logic [PW-1:0]      link_rdata;

    logic               val_we;
    logic               link_we;
    logic [SW-1:0]      waddr;
    logic [PW-1:0]      link_wdata;
    logic               top_we;
    logic [PW-1:0]      top_next;
    logic [PW-1:0]      free_head_next;
    result_t            result_next;
    logic               push_refused;

    assign accept     = start && !busy;
    assign acc_exists = (32'(cmd.stack_id) < STACK_COUNT);
    assign acc_idx    = cmd.stack_id[TIW-1:0];
    assign acc_top    = acc_exists ? tops_reg[acc_idx] : NULL_PTR;
    assign link_raddr = (cmd.op == OP_PUSH) ? free_head_reg[SW-1:0] : acc_top[SW-1:0];

    kss_slot_mem #(
        .SLOT_COUNT(SLOT_COUNT),
        .SW        (SW),
        .PW        (PW)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .val_raddr (acc_top[SW-1:0]),
        .link_raddr(link_raddr),
        .val_rdata (val_rdata),
        .link_rdata(link_rdata),
        .val_we    (val_we),
        .link_we   (link_we),
        .waddr     (waddr),
        .val_wdata (val_reg),
        .link_wdata(link_wdata)
    );

    // busy cycle: memory data is back, update pointers and write the value and links
    always_comb
    begin
        val_we         = 1'b0;
        link_we        = 1'b0;
        waddr          = free_head_reg[SW-1:0];
        link_wdata     = top_reg;
        top_we         = 1'b0;
        top_next       = top_reg;
        free_head_next = free_head_reg;
        result_next.result_value = '0;
        result_next.status       = ST_OK;
        result_next.stack_empty  = (top_reg == NULL_PTR);
        case (op_reg)
            OP_PUSH:
            begin
                if (!exists_reg || (free_head_reg == NULL_PTR))
                begin
                    result_next.status = ST_OVERFLOW;
                end
                else
                begin
                    val_we         = valid_reg;
                    link_we        = valid_reg;
                    top_we         = valid_reg;
                    top_next       = free_head_reg;
                    free_head_next = link_rdata;
                    result_next.stack_empty = 1'b0;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (top_reg == NULL_PTR)
                begin
                    result_next.status       = ST_UNDERFLOW;
                    result_next.result_value = UNDERFLOW_VALUE;
                end
                else
                begin
                    result_next.result_value = val_rdata;
                    if (op_reg == OP_POP)
                    begin
                        link_we        = valid_reg;
                        waddr          = top_reg[SW-1:0];
                        link_wdata     = free_head_reg;
                        top_we         = valid_reg;
                        top_next       = link_rdata;
                        free_head_next = top_reg;
                        result_next.stack_empty = (link_rdata == NULL_PTR);
                    end
                end
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            done_reg      <= 1'b0;
            free_head_reg <= '0;
            for (int i = 0; i < TOPS; i++)
            begin
                tops_reg[i] <= NULL_PTR;
            end
        end
        else
        begin
            valid_reg <= accept;
            done_reg  <= valid_reg;
            if (valid_reg)
            begin
                free_head_reg <= free_head_next;
            end
            if (top_we)
            begin
                tops_reg[idx_reg] <= top_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cmd.op;
            idx_reg    <= acc_idx;
            exists_reg <= acc_exists;
            val_reg    <= cmd.push_value;
            top_reg    <= acc_top;
        end
        if (valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = valid_reg;
    assign done   = done_reg;
    assign result = result_reg;

    assign push_refused = valid_reg && (result_next.status == ST_OVERFLOW);

    `KSS_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
    `KSS_ASSERT_NEXT(a_busy_done, busy, done, "busy cycle not followed by a result")
    `KSS_ASSERT_NOW(a_done_free, done, !busy, "result overlaps a transaction in flight")
    `KSS_ASSERT_NEXT(a_overflow_hold, push_refused, $stable(free_head_reg), "free head moved")

endmodule

>>> hdl/kss_slot_mem.sv
// slot value and link memories; links start as a chain through a fill count
module kss_slot_mem #(
    parameter int SLOT_COUNT = 256,
    parameter int SW         = 8,
    parameter int PW         = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SW-1:0]     val_raddr,
    input  logic [SW-1:0]     link_raddr,
    output logic signed [31:0] val_rdata,
    output logic [PW-1:0]     link_rdata,
    input  logic              val_we,
    input  logic              link_we,
    input  logic [SW-1:0]     waddr,
    input  logic signed [31:0] val_wdata,
    input  logic [PW-1:0]     link_wdata
);
    import kss_pkg::*;

    logic signed [31:0] val_mem [SLOT_COUNT];
    logic [PW-1:0]      link_mem [SLOT_COUNT];

    logic [PW-1:0] fill_reg;
    logic [PW-1:0] fill_next;
    logic [PW-1:0] link_q_reg;
    logic [SW-1:0] link_addr_reg;
    logic          untouched_reg;

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[waddr] <= val_wdata;
        end
        if (link_we)
        begin
            link_mem[waddr] <= link_wdata;
        end
        val_rdata     <= val_mem[val_raddr];
        link_q_reg    <= link_mem[link_raddr];
        link_addr_reg <= link_raddr;
        untouched_reg <= (PW'(link_raddr) >= fill_reg);
    end

    // slots at or above the fill count were never linked, so they still chain to the next
    always_comb
    begin
        fill_next = fill_reg;
        if (link_we && (PW'(waddr) == fill_reg))
        begin
            fill_next = fill_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign link_rdata = untouched_reg ? (PW'(link_addr_reg) + PW'(1)) : link_q_reg;

endmodule
